/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/lpd_pkg.sv */
// package with widths, codes and types of the load permille governor
`default_nettype none

package lpd_pkg;

  localparam int NUM_CORES  = 8;
  localparam int CORE_IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  localparam int CORE_W     = 3;
  localparam int CNT_W      = 64;
  localparam int LOAD_W     = 10;
  localparam int POINT_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int PERMILLE_SCALE = 1000;
  localparam int LOW_THR_RST    = 250;
  localparam int HIGH_THR_RST   = 700;

  // 1000 = 1024 - 32 + 8
  localparam int MUL_SH_A = 10;
  localparam int MUL_SH_B = 5;
  localparam int MUL_SH_C = 3;

  localparam int PROD_W    = CNT_W + LOAD_W;
  localparam int DIV_STEPS = LOAD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [POINT_W-1:0] {
    POINT_LOW     = 2'd0,
    POINT_NOMINAL = 2'd1,
    POINT_HIGH    = 2'd2
  } point_t;

  typedef enum logic {
    CMD_INIT   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THR  = 1'b0,
    REG_HIGH_THR = 1'b1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DELTA = 6'b000010,
    ST_MULT  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_PICK  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

endpackage

`default_nettype wire

/* rtl/lpd_if.sv */
// valid/ready channel interfaces for counter snapshots and governor results
`default_nettype none

interface lpd_in_if;
  import lpd_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [CORE_W-1:0] core;
  logic [CNT_W-1:0]  cycle_count;
  logic [CNT_W-1:0]  event_count;

  modport source (output valid, command, core, cycle_count, event_count, input ready);
  modport sink   (input valid, command, core, cycle_count, event_count, output ready);
endinterface

interface lpd_out_if;
  import lpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CORE_W-1:0]  core_out;
  logic [LOAD_W-1:0]  core_load;
  logic [POINT_W-1:0] operating_point;
  logic               point_changed;
  logic               sample_valid;

  modport source (output valid, core_out, core_load, operating_point, point_changed,
                  sample_valid, input ready);
  modport sink   (input valid, core_out, core_load, operating_point, point_changed,
                  sample_valid, output ready);
endinterface

`default_nettype wire

/* rtl/load_permille_dvfs_governor.sv */
// top level of the per-core load permille dvfs governor
// sequence: init, zero-delta or bad-core beats go from delta to fin, then to the output;
//   a load sample goes delta, multiply, 10 bit-serial divide steps, pick, out
// throughput: one beat at a time; next beat accepted the cycle after the result is
//   registered, and fin waits while the output register holds an untaken result
// reset: synchronous active low; clears per-core ready bits, thresholds to 250 / 700
`default_nettype none
`include "assert_macros.svh"

module load_permille_dvfs_governor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  lpd_in_if.sink                                in_ch,
  lpd_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [lpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lpd_pkg::*;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [CORE_W-1:0]    core_r;
  logic [CNT_W-1:0]     cyc_r, evt_r;
  logic [CNT_W-1:0]     dc_r, dc_nxt;
  logic [CNT_W-1:0]     de_r, de_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [LOAD_W-1:0]    num_r, num_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;

  logic [LOAD_W-1:0]    res_load_r, res_load_nxt;
  point_t               res_point_r, res_point_nxt;
  logic                 res_changed_r, res_changed_nxt;
  logic                 res_sample_r, res_sample_nxt;

  logic [LOAD_W-1:0]    low_thr_r, high_thr_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [CORE_W-1:0]    out_core_r;
  logic [LOAD_W-1:0]    out_load_r;
  point_t               out_point_r;
  logic                 out_changed_r;
  logic                 out_sample_r;

  // per-core state
  logic [CNT_W-1:0]     base_cyc_r  [NUM_CORES];
  logic [CNT_W-1:0]     base_evt_r  [NUM_CORES];
  logic [LOAD_W-1:0]    last_load_r [NUM_CORES];
  point_t               cur_point_r [NUM_CORES];
  logic [NUM_CORES-1:0] core_ready_r;

  logic [CORE_IDX_W-1:0] idx;
  logic                  core_ok;
  logic                  in_acc;
  logic                  out_load_en;
  logic                  wr_base, wr_init, wr_pick;
  logic [CNT_W-1:0]      dc_calc, de_calc;
  logic [PROD_W-1:0]     prod;
  logic [CNT_W:0]        rem_sh;
  logic                  div_ge;
  point_t                pick_point;
  point_t                rd_point;

  assign idx     = CORE_IDX_W'(core_r);
  assign core_ok = (32'(core_r) < 32'(NUM_CORES));
  assign in_acc  = in_ch.valid && in_ch.ready;

  assign in_ch.ready = (state_r == ST_IDLE);

  assign dc_calc = cyc_r - base_cyc_r[idx];
  assign de_calc = evt_r - base_evt_r[idx];
  assign rd_point = cur_point_r[idx];

  assign prod = (PROD_W'(de_r) << MUL_SH_A) - (PROD_W'(de_r) << MUL_SH_B)
              + (PROD_W'(de_r) << MUL_SH_C);

  // one restoring divide step: next numerator bit into the remainder
  assign rem_sh = {rem_r, num_r[LOAD_W-1]};
  assign div_ge = (rem_sh >= {1'b0, dc_r});

  always_comb begin
    if (num_r >= high_thr_r) begin
      pick_point = POINT_HIGH;
    end else if (num_r <= low_thr_r) begin
      pick_point = POINT_LOW;
    end else if (rd_point == POINT_HIGH || rd_point == POINT_LOW) begin
      pick_point = POINT_NOMINAL;
    end else begin
      pick_point = rd_point;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    dc_nxt          = dc_r;
    de_nxt          = de_r;
    rem_nxt         = rem_r;
    num_nxt         = num_r;
    step_nxt        = step_r;
    res_load_nxt    = res_load_r;
    res_point_nxt   = res_point_r;
    res_changed_nxt = res_changed_r;
    res_sample_nxt  = res_sample_r;
    wr_base         = 1'b0;
    wr_init         = 1'b0;
    wr_pick         = 1'b0;
    out_load_en     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        res_changed_nxt = 1'b0;
        res_sample_nxt  = 1'b0;
        if (!core_ok) begin
          res_load_nxt  = '0;
          res_point_nxt = POINT_NOMINAL;
          state_nxt     = ST_FIN;
        end else if (cmd_r == CMD_INIT || !core_ready_r[idx]) begin
          wr_base       = 1'b1;
          wr_init       = 1'b1;
          res_load_nxt  = '0;
          res_point_nxt = POINT_NOMINAL;
          state_nxt     = ST_FIN;
        end else begin
          wr_base = 1'b1;
          if (dc_calc == '0) begin
            res_load_nxt  = last_load_r[idx];
            res_point_nxt = rd_point;
            state_nxt     = ST_FIN;
          end else begin
            dc_nxt    = dc_calc;
            de_nxt    = (de_calc > dc_calc) ? dc_calc : de_calc;
            state_nxt = ST_MULT;
          end
        end
      end
      ST_MULT: begin
        rem_nxt   = prod[PROD_W-1:LOAD_W];
        num_nxt   = prod[LOAD_W-1:0];
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? CNT_W'(rem_sh - {1'b0, dc_r}) : CNT_W'(rem_sh);
        num_nxt  = {num_r[LOAD_W-2:0], div_ge};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        wr_pick         = 1'b1;
        res_load_nxt    = num_r;
        res_point_nxt   = pick_point;
        res_changed_nxt = (pick_point != rd_point);
        res_sample_nxt  = 1'b1;
        state_nxt       = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load_en = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load_en || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      low_thr_r    <= LOAD_W'(LOW_THR_RST);
      high_thr_r   <= LOAD_W'(HIGH_THR_RST);
      core_ready_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_init) begin
        core_ready_r[idx] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LOW_THR:  low_thr_r  <= cfg_data;
          REG_HIGH_THR: high_thr_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= cmd_t'(in_ch.command);
      core_r <= in_ch.core;
      cyc_r  <= in_ch.cycle_count;
      evt_r  <= in_ch.event_count;
    end
    dc_r          <= dc_nxt;
    de_r          <= de_nxt;
    rem_r         <= rem_nxt;
    num_r         <= num_nxt;
    step_r        <= step_nxt;
    res_load_r    <= res_load_nxt;
    res_point_r   <= res_point_nxt;
    res_changed_r <= res_changed_nxt;
    res_sample_r  <= res_sample_nxt;
    if (out_load_en) begin
      out_core_r    <= core_r;
      out_load_r    <= res_load_nxt;
      out_point_r   <= res_point_nxt;
      out_changed_r <= res_changed_nxt;
      out_sample_r  <= res_sample_nxt;
    end
    if (wr_base) begin
      base_cyc_r[idx] <= cyc_r;
      base_evt_r[idx] <= evt_r;
    end
    if (wr_init) begin
      last_load_r[idx] <= '0;
      cur_point_r[idx] <= POINT_NOMINAL;
    end else if (wr_pick) begin
      last_load_r[idx] <= num_r;
      cur_point_r[idx] <= pick_point;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.core_out        = out_core_r;
  assign out_ch.core_load       = out_load_r;
  assign out_ch.operating_point = out_point_r;
  assign out_ch.point_changed   = out_changed_r;
  assign out_ch.sample_valid    = out_sample_r;

  `ASSERT_NEXT(a_accept_to_delta, clk, rst_n, in_acc, state_r == ST_DELTA)
  `ASSERT_IMPL(a_div_rem_below_den, clk, rst_n, state_r == ST_DIV, rem_r < dc_r)
  `ASSERT_IMPL(a_out_load_max, clk, rst_n, out_valid_r,
               out_load_r <= LOAD_W'(PERMILLE_SCALE))
  `ASSERT_IMPL(a_change_needs_sample, clk, rst_n, out_valid_r && out_changed_r,
               out_sample_r)
  `ASSERT_NEXT(a_fin_delivers, clk, rst_n,
               state_r == ST_FIN && (!out_valid_r || out_ch.ready),
               out_valid_r && state_r == ST_IDLE)

endmodule

`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for the per-core load permille dvfs governor
`timescale 1ns / 100ps

module testbench;
  import lpd_pkg::*;

  typedef struct {
    logic [CORE_W-1:0]  core;
    logic [LOAD_W-1:0]  load;
    logic [POINT_W-1:0] point;
    logic               changed;
    logic               valid;
  } governor_result_t;

  class dvfs_point_tracker;
    logic [CNT_W-1:0]  base_cyc [NUM_CORES];
    logic [CNT_W-1:0]  base_evt [NUM_CORES];
    logic [LOAD_W-1:0] load [NUM_CORES];
    point_t            point [NUM_CORES];
    bit                armed [NUM_CORES];
    logic [LOAD_W-1:0] low_thr;
    logic [LOAD_W-1:0] high_thr;
    governor_result_t  due_results [$];
    int                errors;

    function new();
      for (int i = 0; i < NUM_CORES; i++) begin
        base_cyc[i] = '0;
        base_evt[i] = '0;
        load[i] = '0;
        point[i] = POINT_NOMINAL;
        armed[i] = 1'b0;
      end
      low_thr = LOAD_W'(LOW_THR_RST);
      high_thr = LOAD_W'(HIGH_THR_RST);
      errors = 0;
    endfunction

    function void set_threshold(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_LOW_THR) begin
        low_thr = value;
      end else begin
        high_thr = value;
      end
    endfunction

    function void note_snapshot(cmd_t cmd, logic [CORE_W-1:0] core,
                                logic [CNT_W-1:0] cyc, logic [CNT_W-1:0] evt);
      governor_result_t r;
      logic [CNT_W-1:0]  dc;
      logic [CNT_W-1:0]  de;
      logic [PROD_W-1:0] wide;
      point_t            next;
      r.core = core;
      r.changed = 1'b0;
      r.valid = 1'b0;
      if (cmd == CMD_INIT || !armed[core]) begin
        base_cyc[core] = cyc;
        base_evt[core] = evt;
        load[core] = '0;
        point[core] = POINT_NOMINAL;
        armed[core] = 1'b1;
      end else begin
        dc = cyc - base_cyc[core];
        de = evt - base_evt[core];
        base_cyc[core] = cyc;
        base_evt[core] = evt;
        if (dc != '0) begin
          if (de > dc) de = dc;
          wide = {{LOAD_W{1'b0}}, de} * PROD_W'(PERMILLE_SCALE);
          wide = wide / {{LOAD_W{1'b0}}, dc};
          load[core] = wide[LOAD_W-1:0];
          if (load[core] >= high_thr) begin
            next = POINT_HIGH;
          end else if (load[core] <= low_thr) begin
            next = POINT_LOW;
          end else begin
            next = POINT_NOMINAL;
          end
          if (next != point[core]) begin
            point[core] = next;
            r.changed = 1'b1;
          end
          r.valid = 1'b1;
        end
      end
      r.load = load[core];
      r.point = point[core];
      due_results.push_back(r);
    endfunction

    function void check_result(governor_result_t got);
      governor_result_t want;
      if (due_results.size() == 0) begin
        $error("result beat for core %0d with no snapshot pending", got.core);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (want.core !== got.core) begin
        $error("core_out expected %0d got %0d", want.core, got.core);
        errors++;
      end
      if (want.load !== got.load) begin
        $error("core_load expected %0d got %0d", want.load, got.load);
        errors++;
      end
      if (want.point !== got.point) begin
        $error("operating_point expected %0d got %0d", want.point, got.point);
        errors++;
      end
      if (want.changed !== got.changed) begin
        $error("point_changed expected %0d got %0d", want.changed, got.changed);
        errors++;
      end
      if (want.valid !== got.valid) begin
        $error("sample_valid expected %0d got %0d", want.valid, got.valid);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    in_gaps;
  bit                    out_gaps;
  bit                    hold_request;
  int                    hold_left;

  dvfs_point_tracker tracker = new();

  lpd_in_if  in_bus ();
  lpd_out_if out_bus ();

  load_permille_dvfs_governor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic offer_snapshot(input cmd_t cmd, input logic [CORE_W-1:0] core,
                                input logic [CNT_W-1:0] cyc, input logic [CNT_W-1:0] evt);
    if (in_gaps) begin
      while ($urandom_range(99) < 17) begin
        in_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.core <= core;
    in_bus.cycle_count <= cyc;
    in_bus.event_count <= evt;
    do @(posedge clk); while (!in_bus.ready);
    tracker.note_snapshot(cmd, core, cyc, evt);
  endtask

  // sample relative to the core's current baseline
  task automatic sample_by(input logic [CORE_W-1:0] core, input logic [CNT_W-1:0] dc,
                           input logic [CNT_W-1:0] de);
    offer_snapshot(CMD_SAMPLE, core, tracker.base_cyc[core] + dc, tracker.base_evt[core] + de);
  endtask

  task automatic random_snapshot();
    logic [CORE_W-1:0] c;
    logic [CNT_W-1:0]  dc;
    logic [CNT_W-1:0]  de;
    logic [PROD_W-1:0] wide;
    int                kind;
    int                pct;
    c = CORE_W'($urandom_range(NUM_CORES - 1));
    kind = $urandom_range(99);
    if (kind < 5) begin
      offer_snapshot(CMD_INIT, c, {$urandom, $urandom}, {$urandom, $urandom});
    end else if (kind < 10) begin
      offer_snapshot(CMD_SAMPLE, c, {$urandom, $urandom}, {$urandom, $urandom});
    end else if (kind < 15) begin
      sample_by(c, '0, {$urandom, $urandom});
    end else begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        dc = CNT_W'($urandom_range(1, 2000));
      end else if (kind < 70) begin
        dc = CNT_W'($urandom_range(1, 20));
      end else if (kind < 92) begin
        dc = {32'd0, $urandom};
      end else begin
        dc = {$urandom, $urandom};
      end
      if ($urandom_range(9) == 0) begin
        de = dc + CNT_W'($urandom_range(1, 50));
      end else begin
        if ($urandom_range(1) == 1) begin
          pct = int'($urandom_range(1000));
        end else begin
          pct = ($urandom_range(1) == 1) ? int'(tracker.low_thr) : int'(tracker.high_thr);
          pct = pct + int'($urandom_range(4)) - 2;
          if (pct < 0) pct = 0;
          if (pct > PERMILLE_SCALE) pct = PERMILLE_SCALE;
        end
        wide = {{LOAD_W{1'b0}}, dc} * PROD_W'(pct);
        wide = wide / PROD_W'(PERMILLE_SCALE);
        de = wide[CNT_W-1:0] + CNT_W'($urandom_range(1));
      end
      sample_by(c, dc, de);
    end
  endtask

  task automatic write_thresholds(input logic [CFG_DATA_W-1:0] lo,
                                  input logic [CFG_DATA_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_LOW_THR;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_HIGH_THR;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_threshold(REG_LOW_THR, lo);
    tracker.set_threshold(REG_HIGH_THR, hi);
  endtask

  task automatic drain_results();
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_LOW_THR;
    cfg_data <= '0;
    in_bus.valid <= 1'b0;
    in_bus.command <= CMD_INIT;
    in_bus.core <= '0;
    in_bus.cycle_count <= '0;
    in_bus.event_count <= '0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1: begin lo = 10'd0;   hi = 10'd1000; end
          2: begin lo = 10'd999; hi = 10'd1;    end
          3: begin lo = 10'd500; hi = 10'd500;  end
          4: begin lo = 10'd100; hi = 10'd900;  end
          5: begin
            lo = CFG_DATA_W'($urandom_range(999));
            hi = CFG_DATA_W'($urandom_range(1, 1000));
          end
          default: begin lo = 10'd250; hi = 10'd700; end
        endcase
        write_thresholds(lo, hi);
      end
      in_gaps = (ph != 3);
      out_gaps = (ph != 3);
      if (ph == 2) hold_request = 1'b1;
      if (ph == 0) begin
        // first sample on a core that is not ready acts as init
        offer_snapshot(CMD_SAMPLE, 3'd0, 64'd100, 64'd50);
        sample_by(3'd0, 64'd1000, 64'd700);
        sample_by(3'd0, 64'd1000, 64'd250);
        sample_by(3'd0, 64'd1000, 64'd500);
        sample_by(3'd0, 64'd1000, 64'd500);
        // zero elapsed cycles
        sample_by(3'd0, 64'd0, 64'd123);
        // more events than cycles
        sample_by(3'd0, 64'd1000, 64'd5000);
        sample_by(3'd0, 64'd1000, 64'd0);
        offer_snapshot(CMD_INIT, 3'd7, '1, '1);
        // counters wrap
        sample_by(3'd7, 64'd1000, 64'd1);
        sample_by(3'd7, '1, '1);
        sample_by(3'd7, '1, 64'h8000_0000_0000_0000);
        offer_snapshot(CMD_INIT, 3'd0, 64'd7, 64'd3);
        offer_snapshot(CMD_SAMPLE, 3'd3, '0, '0);
        sample_by(3'd3, 64'd1, 64'd0);
        sample_by(3'd3, 64'd1, 64'd1);
        sample_by(3'd3, 64'd3, 64'd1);
        offer_snapshot(CMD_INIT, 3'd5, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        sample_by(3'd5, 64'h5555_5555_5555_5555, 64'h2222_2222_2222_2222);
        offer_snapshot(CMD_INIT, 3'd5, '0, '0);
        sample_by(3'd5, 64'd4, 64'd3);
      end
      repeat (290) random_snapshot();
      in_bus.valid <= 1'b0;
    end
    drain_results();
    if (tracker.errors == 0) begin
      $display("load_permille_dvfs_governor: match");
    end else begin
      $display("load_permille_dvfs_governor: mismatch");
    end
    $finish;
  end

  // result side: checks each beat and throttles ready
  initial begin
    governor_result_t got;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        got.core = out_bus.core_out;
        got.load = out_bus.core_load;
        got.point = out_bus.operating_point;
        got.changed = out_bus.point_changed;
        got.valid = out_bus.sample_valid;
        tracker.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(out_gaps && $urandom_range(99) < 17);
      end
    end
  end

  initial begin
    #5ms;
    $display("load_permille_dvfs_governor: mismatch");
    $finish;
  end

endmodule

/* load_permille_dvfs_governor.f */
+incdir+rtl
rtl/lpd_pkg.sv
rtl/lpd_if.sv
rtl/load_permille_dvfs_governor.sv
dv/testbench.sv
